@@ rtl/sgw_pkg.sv @@
// shared types, constants and helpers of the sobel gradient window unit
package sgw_pkg;

  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned GRAD_W      = 11;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned CFG_W       = 11;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned GRAD_LIMIT  = 1020;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [CFG_W-1:0] DIM_MIN      = 11'd3;

  // configuration register index
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [SUM_W-1:0]   wsum_t;
  typedef logic signed [GRAD_W-1:0] grad_t;

  // weighted 1,2,1 sum of three pixels
  function automatic wsum_t wsum(input pixel_t a, input pixel_t b, input pixel_t c);
    wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  // difference of two weighted sums, always within the gradient range
  function automatic grad_t wdiff(input wsum_t p, input wsum_t n);
    wdiff = grad_t'({1'b0, p} - {1'b0, n});
  endfunction

endpackage

@@ rtl/sobel_gradient_window_unit.sv @@
// streaming 3x3 sobel gradient unit with replicated borders
//
//  channel   | dir | fields (lsb first)                                  | transfer when
//  ----------+-----+-----------------------------------------------------+--------------------
//  s_axis    | in  | tdata: pixel[7:0]                                   | tvalid & tready
//  m_axis    | out | tdata: grad_x, grad_y, out_row, out_col; tlast:     | tvalid & tready
//            |     |   last_of_run; tuser: frame_done                    |
//  cfg       | in  | cfg_addr_i: register index, cfg_wdata_i: value      | cfg_we_i
//
// a pixel goes through two stages: the input stage holds it while the line buffer
// word at its column is read, the window stage holds the 3x3 window and hands out
// up to four results through one shared sobel adder set into the output register
// one pixel per cycle while each pixel gives at most one result and the output
// is not stalled; a pixel that gives more (last column and last row) holds the
// window stage until its last result goes into the output register
// reset clears control, counters, window; sizes go to 640x480; line buffer not cleared
// a stalled output holds its result and backs up into the input stage and tready
module sobel_gradient_window_unit
  import sgw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration writes
  input  logic                   cfg_we_i,
  input  logic [0:0]             cfg_addr_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  // pixel input
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pixel[7:0]
  // gradient output
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // grad_x, grad_y, out_row, out_col, zero pad
  output logic                   m_axis_tlast,   // last_of_run
  output logic                   m_axis_tuser    // frame_done
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned PAD_W = OUT_TDATA_W - 2 * GRAD_W - 2 * POS_W;

  // ---------------------------------------------------------------- configuration
  logic [CFG_W-1:0] cfg_width_q, cfg_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RESET;
      cfg_height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_IMAGE_WIDTH:  cfg_width_q  <= cfg_wdata_i;
        REG_IMAGE_HEIGHT: cfg_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped size, as last index
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;

  always_comb begin
    if (cfg_width_q < DIM_MIN)                  last_col = CW'(2);
    else if (32'(cfg_width_q) > MAX_WIDTH)      last_col = CW'(MAX_WIDTH - 1);
    else                                        last_col = CW'(cfg_width_q - 11'd1);
    if (cfg_height_q < DIM_MIN)                 last_row = RW'(2);
    else if (32'(cfg_height_q) > MAX_HEIGHT)    last_row = RW'(MAX_HEIGHT - 1);
    else                                        last_row = RW'(cfg_height_q - 11'd1);
  end

  // ---------------------------------------------------------------- handshake
  logic a_valid_q;
  logic b_free;
  logic accept, a_move;

  assign s_axis_tready = !a_valid_q || b_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign a_move        = a_valid_q && b_free;

  // ---------------------------------------------------------------- position counters
  logic [CW-1:0] col_cnt_q;
  logic [RW-1:0] row_cnt_q;
  logic          in_lastc, in_lastr;

  assign in_lastc = col_cnt_q >= last_col;
  assign in_lastr = row_cnt_q >= last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else if (accept) begin
      if (in_lastc) begin
        col_cnt_q <= '0;
        row_cnt_q <= in_lastr ? '0 : row_cnt_q + RW'(1);
      end else begin
        col_cnt_q <= col_cnt_q + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------- input stage
  pixel_t        a_px_q;
  logic [CW-1:0] a_col_q;
  logic [RW-1:0] a_row_q;
  logic          a_lastc_q, a_lastr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_valid_q <= 1'b0;
    else         a_valid_q <= accept || (a_valid_q && !b_free);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_px_q    <= s_axis_tdata[PIXEL_W-1:0];
      a_col_q   <= col_cnt_q;
      a_row_q   <= row_cnt_q;
      a_lastc_q <= in_lastc;
      a_lastr_q <= in_lastr;
    end
  end

  // line buffer: each word holds {two rows up, one row up} of a column
  // read at transfer, written back shifted when the pixel leaves the input stage;
  // the two addresses of one cycle always differ
  logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIXEL_W-1:0] line_rd_q;

  always_ff @(posedge clk_i) begin
    if (a_move) line_mem[a_col_q] <= {line_rd_q[PIXEL_W-1:0], a_px_q};
    if (accept) line_rd_q <= line_mem[col_cnt_q];
  end

  // ---------------------------------------------------------------- window stage
  // win_q[row][col]: row 0 top, 2 bottom; col 0 left, 2 right
  pixel_t        win_q [3][3];
  pixel_t        col_new [3];
  logic [3:0]    b_mask_q;      // upper left, upper edge, lower left, lower edge
  logic [CW-1:0] b_col_q;
  logic [RW-1:0] b_row_q;
  logic          b_top_mid_q;   // second row: top replicates middle
  logic [3:0]    a_mask;

  assign col_new[0] = line_rd_q[2*PIXEL_W-1:PIXEL_W];
  assign col_new[1] = line_rd_q[PIXEL_W-1:0];
  assign col_new[2] = a_px_q;

  always_comb begin
    logic r_ok, c_ok;
    r_ok = a_row_q != '0;
    c_ok = a_col_q != '0;
    a_mask[0] = r_ok && c_ok;
    a_mask[1] = r_ok && a_lastc_q;
    a_mask[2] = r_ok && a_lastr_q && c_ok;
    a_mask[3] = r_ok && a_lastr_q && a_lastc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) win_q[k][j] <= '0;
      end
    end else if (a_move) begin
      for (int k = 0; k < 3; k++) begin
        if (a_col_q == '0) begin
          win_q[k][0] <= col_new[k];
          win_q[k][1] <= col_new[k];
        end else begin
          win_q[k][0] <= win_q[k][1];
          win_q[k][1] <= win_q[k][2];
        end
        win_q[k][2] <= col_new[k];
      end
    end
  end

  // result selection: lowest pending result goes first
  logic       out_free, emit;
  logic [3:0] sel, mask_rest;

  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign emit      = (b_mask_q != '0) && out_free;
  assign sel       = b_mask_q & (~b_mask_q + 4'd1);
  assign mask_rest = b_mask_q & ~sel;
  assign b_free    = (b_mask_q == '0) || (emit && mask_rest == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)     b_mask_q <= '0;
    else if (a_move) b_mask_q <= a_mask;
    else if (emit)   b_mask_q <= mask_rest;
  end

  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_col_q     <= a_col_q;
      b_row_q     <= a_row_q;
      b_top_mid_q <= a_row_q == RW'(1);
    end
  end

  // shared sobel datapath
  logic   lower, edge_col;
  pixel_t tp [3], mp [3], bp [3];
  pixel_t t_l, t_c, t_r, m_l, m_r, b_l, b_c, b_r;
  grad_t  gx, gy;
  logic [POS_W-1:0] res_row, res_col;

  assign lower    = sel[2] || sel[3];
  assign edge_col = sel[1] || sel[3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      tp[j] = lower ? win_q[1][j] : (b_top_mid_q ? win_q[1][j] : win_q[0][j]);
      mp[j] = lower ? win_q[2][j] : win_q[1][j];
      bp[j] = win_q[2][j];
    end
  end

  // the right border replicates the last column
  assign t_l = edge_col ? tp[1] : tp[0];
  assign t_c = edge_col ? tp[2] : tp[1];
  assign t_r = tp[2];
  assign m_l = edge_col ? mp[1] : mp[0];
  assign m_r = mp[2];
  assign b_l = edge_col ? bp[1] : bp[0];
  assign b_c = edge_col ? bp[2] : bp[1];
  assign b_r = bp[2];

  assign gx = wdiff(wsum(t_r, m_r, b_r), wsum(t_l, m_l, b_l));
  assign gy = wdiff(wsum(b_l, b_c, b_r), wsum(t_l, t_c, t_r));

  assign res_row = lower    ? POS_W'(b_row_q) : POS_W'(b_row_q - RW'(1));
  assign res_col = edge_col ? POS_W'(b_col_q) : POS_W'(b_col_q - CW'(1));

  // ---------------------------------------------------------------- output register
  logic m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            m_valid_q <= 1'b0;
    else if (emit)          m_valid_q <= 1'b1;
    else if (m_axis_tready) m_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_axis_tdata <= {{PAD_W{1'b0}}, res_col, res_row, gy, gx};
      m_axis_tlast <= mask_rest == '0;
      m_axis_tuser <= sel[3];
    end
  end

  assign m_axis_tvalid = m_valid_q;

endmodule

@@ rtl/sgw_checker.sv @@
// port checker of the sobel gradient window unit, bound to the top level
module sgw_checker
  import sgw_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast,
  input logic                   m_axis_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("output payload changed while stalled");

  // the frame's final result closes its pixel's run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("frame end without end of run");

  // gradients stay inside the sobel range
  a_grad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      $signed(m_axis_tdata[GRAD_W-1:0]) >= -$signed(12'(GRAD_LIMIT)) &&
      $signed(m_axis_tdata[GRAD_W-1:0]) <= $signed(12'(GRAD_LIMIT)) &&
      $signed(m_axis_tdata[2*GRAD_W-1:GRAD_W]) >= -$signed(12'(GRAD_LIMIT)) &&
      $signed(m_axis_tdata[2*GRAD_W-1:GRAD_W]) <= $signed(12'(GRAD_LIMIT)))
    else $error("gradient out of range");

endmodule

bind sobel_gradient_window_unit sgw_checker u_sgw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

@@ tb/tb_sobel_gradient_window_unit.sv @@
`timescale 1ns / 100ps
// self-checking testbench of the streaming sobel gradient window unit
module tb_sobel_gradient_window_unit;
  import sgw_pkg::*;

  localparam int unsigned MAX_DIM        = 1024;
  localparam int unsigned RANDOM_PIXELS  = 250;  // random stimulus stops past this count
  localparam int unsigned LONG_HOLD      = 200;  // sets the length of the one long output stall
  localparam int unsigned HOLD_AFTER     = 40;   // pixels accepted before that stall starts
  localparam int unsigned SETTLE_CYCLES  = 8;    // quiet cycles after the last result
  localparam int unsigned DRAIN_LIMIT    = 20000;
  localparam int unsigned MAX_REPORTS    = 50;

  // one expected gradient result
  typedef struct packed {
    grad_t            gx;
    grad_t            gy;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic             fdone;
  } gradient_t;

  typedef int trio_t [3];

  // pixel content of a frame
  typedef enum logic [0:0] {
    PIX_RANDOM  = 1'b0,
    PIX_EXTREME = 1'b1
  } pixel_kind_e;

  // mirrors line buffers, window and counters of the unit and queues the
  // gradients each accepted pixel is due to produce
  class sobel_checker;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pixel_t           upper_line [MAX_DIM];
    pixel_t           middle_line [MAX_DIM];
    pixel_t           window [9];
    int unsigned      col_cnt;
    int unsigned      row_cnt;
    gradient_t        pending_grads [$];
    gradient_t        burst [$];
    int unsigned      mismatches;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_line[i]) upper_line[i] = '0;
      foreach (middle_line[i]) middle_line[i] = '0;
      foreach (window[i]) window[i] = '0;
      col_cnt    = 0;
      row_cnt    = 0;
      mismatches = 0;
    endfunction

    // sizes below three or above the maximum are taken as the nearest limit
    function int unsigned clamp_dim(logic [CFG_W-1:0] v);
      if (v < DIM_MIN) return 3;
      if (v > MAX_DIM) return MAX_DIM;
      return int'(v);
    endfunction

    function int unsigned frame_pixels();
      return clamp_dim(width_reg) * clamp_dim(height_reg);
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = val;
        REG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // rows top, middle, bottom, each left, centre, right
    function void add_result(trio_t t, trio_t m, trio_t b, int unsigned row,
                             int unsigned col, bit fdone);
      gradient_t g;
      int        gx;
      int        gy;
      gx      = (t[2] + 2 * m[2] + b[2]) - (t[0] + 2 * m[0] + b[0]);
      gy      = (b[0] + 2 * b[1] + b[2]) - (t[0] + 2 * t[1] + t[2]);
      g.gx    = grad_t'(gx);
      g.gy    = grad_t'(gy);
      g.row   = POS_W'(row);
      g.col   = POS_W'(col);
      g.last  = 1'b0;
      g.fdone = fdone;
      burst   = {burst, g};
    endfunction

    // centre at col-1, then on the last column the centre at col itself with
    // the right edge replicated
    function void add_row(trio_t t, trio_t m, trio_t b, int unsigned row,
                          int unsigned col, bit on_last_col, bit fdone);
      trio_t t2;
      trio_t m2;
      trio_t b2;
      if (col >= 1) add_result(t, m, b, row, col - 1, 1'b0);
      if (on_last_col) begin
        t2 = '{t[1], t[2], t[2]};
        m2 = '{m[1], m[2], m[2]};
        b2 = '{b[1], b[2], b[2]};
        add_result(t2, m2, b2, row, col, fdone);
      end
    endfunction

    function void take_pixel(pixel_t px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      bit          last_col;
      bit          last_row;
      pixel_t      col_new [3];
      trio_t       t;
      trio_t       m;
      trio_t       b;
      w        = clamp_dim(width_reg);
      h        = clamp_dim(height_reg);
      c        = col_cnt;
      r        = row_cnt;
      last_col = (c >= w - 1);
      last_row = (r >= h - 1);

      col_new[0]     = upper_line[c];
      col_new[1]     = middle_line[c];
      col_new[2]     = px;
      upper_line[c]  = middle_line[c];
      middle_line[c] = px;

      for (int k = 0; k < 3; k++) begin
        if (c == 0) begin
          window[k*3]   = col_new[k];
          window[k*3+1] = col_new[k];
        end else begin
          window[k*3]   = window[k*3+1];
          window[k*3+1] = window[k*3+2];
        end
        window[k*3+2] = col_new[k];
      end

      // on the second row the top row is the replicated first row
      for (int j = 0; j < 3; j++) begin
        m[j] = int'(window[3+j]);
        b[j] = int'(window[6+j]);
        t[j] = (r == 1) ? m[j] : int'(window[j]);
      end

      burst.delete();
      if (r >= 1) begin
        add_row(t, m, b, r - 1, c, last_col, 1'b0);
        if (last_row) add_row(m, b, b, r, c, last_col, last_col);
      end
      if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
      pending_grads = {pending_grads, burst};

      if (last_col) begin
        col_cnt = 0;
        row_cnt = last_row ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_gradient(logic [OUT_TDATA_W-1:0] data, logic last, logic fdone);
      gradient_t        want;
      grad_t            gx;
      grad_t            gy;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      gx  = data[GRAD_W-1:0];
      gy  = data[2*GRAD_W-1:GRAD_W];
      row = data[2*GRAD_W+POS_W-1:2*GRAD_W];
      col = data[2*GRAD_W+2*POS_W-1:2*GRAD_W+POS_W];
      if (pending_grads.size() == 0) begin
        report($sformatf("result at (%0d,%0d) with nothing pending", row, col));
      end else begin
        want = pending_grads.pop_front();
        if (gx !== want.gx)
          report($sformatf("grad_x at (%0d,%0d): got %0d want %0d",
                           want.row, want.col, gx, want.gx));
        if (gy !== want.gy)
          report($sformatf("grad_y at (%0d,%0d): got %0d want %0d",
                           want.row, want.col, gy, want.gy));
        if (row !== want.row)
          report($sformatf("out_row: got %0d want %0d", row, want.row));
        if (col !== want.col)
          report($sformatf("out_col at row %0d: got %0d want %0d", want.row, col, want.col));
        if (last !== want.last)
          report($sformatf("last_of_run at (%0d,%0d): got %b want %b",
                           want.row, want.col, last, want.last));
        if (fdone !== want.fdone)
          report($sformatf("frame_done at (%0d,%0d): got %b want %b",
                           want.row, want.col, fdone, want.fdone));
      end
    endtask
  endclass

  // clock, reset and block ports; every input starts at a known value
  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [0:0]             cfg_addr_i    = '0;
  logic [CFG_W-1:0]       cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // pixel[7:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;         // grad_x, grad_y, out_row, out_col, zero pad
  logic                   m_axis_tlast;         // last_of_run
  logic                   m_axis_tuser;         // frame_done

  sobel_checker sb;

  // 0: sender idles 19 %, receiver 78 %; 1: the other way round; 2: no idling
  int unsigned  idle_mode = 0;
  int unsigned  pixels_in = 0;   // accepted pixel transfers so far
  int unsigned  hold_left = 0;
  bit           hold_done = 1'b0;

  sobel_gradient_window_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic int unsigned sender_idle_pct();
    case (idle_mode)
      0:       return 19;
      1:       return 78;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned receiver_idle_pct();
    case (idle_mode)
      0:       return 78;
      1:       return 19;
      default: return 0;
    endcase
  endfunction

  // offer one pixel, with a random gap first, and wait for its transfer;
  // tready is sampled right after the edge, so it is the value the block saw
  task automatic send_pixel(pixel_t px);
    while ($urandom_range(99) < sender_idle_pct()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_pixel(px);
    pixels_in++;
  endtask

  // stop offering, wait until every pending gradient has come out, then let the
  // pipeline run empty before the sizes may change
  task automatic settle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (sb.pending_grads.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // back to back writes of both size registers, only while the unit is idle
  task automatic set_frame_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_IMAGE_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_addr_i  <= REG_IMAGE_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_reg(REG_IMAGE_WIDTH, w);
    sb.write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // one whole frame at the current size
  task automatic send_frame(pixel_kind_e kind, inout int unsigned sent);
    int unsigned n;
    n = sb.frame_pixels();
    repeat (n) begin
      if (kind == PIX_EXTREME) send_pixel($urandom_range(1) ? 8'hFF : 8'h00);
      else send_pixel(PIXEL_W'($urandom_range(255)));
      sent++;
    end
  endtask

  // receiver: random stalls by idle mode, and once a long hold-off so the
  // unit fills up and drops s_axis_tready while pixels keep coming
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (!hold_done && pixels_in >= HOLD_AFTER) begin
      m_axis_tready <= 1'b0;
      hold_left     <= LONG_HOLD;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
    end
  end

  // every output transfer is checked against the oldest pending gradient
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_gradient(m_axis_tdata, m_axis_tlast, m_axis_tuser);
  end

  initial begin
    int unsigned random_sent;
    pixel_kind_e kind;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    random_sent = 0;
    sb          = new();

    // reset held at the start, released once
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: sizes below the minimum act as 3x3
    // vertical edge, dark left and bright right: largest positive grad_x
    set_frame_size(11'd0, 11'd1);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 2) ? 8'hFF : 8'h00);
    settle();

    // bright top and sides around a dark centre, dark bottom row:
    // most negative grad_y
    set_frame_size(11'd2, 11'd2);
    for (int i = 0; i < 9; i++) send_pixel((i < 4 || i == 5) ? 8'hFF : 8'h00);

    // random frames, mostly small, idle mode moving on with the pixel count
    while (random_sent < RANDOM_PIXELS) begin
      settle();
      if (random_sent < RANDOM_PIXELS / 3) idle_mode = 0;
      else if (random_sent < 2 * RANDOM_PIXELS / 3) idle_mode = 1;
      else idle_mode = 2;
      w    = ($urandom_range(7) == 0) ? CFG_W'($urandom_range(13, 40))
                                      : CFG_W'($urandom_range(0, 12));
      h    = CFG_W'($urandom_range(0, 7));
      kind = ($urandom_range(3) == 0) ? PIX_EXTREME : PIX_RANDOM;
      set_frame_size(w, h);
      send_frame(kind, random_sent);
    end

    settle();
    if (sb.pending_grads.size() != 0)
      sb.report($sformatf("%0d gradients never came out", sb.pending_grads.size()));
    if (sb.mismatches == 0) begin
      $display("** sobel_gradient_window_unit: PASSED **");
    end else begin
      $display("** sobel_gradient_window_unit: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #2000000;
    $display("** sobel_gradient_window_unit: FAILED **");
    $finish;
  end

endmodule
